FILE: rtl/core/lcdw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lcdw_pkg;

  localparam int WEIGHT_WIDTH = 24;
  localparam int MAX_REJECTS  = 3;

  // field and register widths
  localparam int RAW_W       = 24;
  localparam int GAIN_W      = 24;
  localparam int TRIM_W      = 17;
  localparam int TARE_W      = 21;
  localparam int GLITCH_W    = 20;
  localparam int CAP_W       = 20;
  localparam int MISSED_W    = 8;
  localparam int ERR_W       = 2;
  localparam int CFG_W       = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int OUT_FIELD_W = 24;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * OUT_FIELD_W - ERR_W;

  localparam int MARGIN      = 1600;
  localparam int FRAC_W      = 16;

  // serial multiplier geometry
  localparam int DIFF_W    = RAW_W + 1;
  localparam int MUL_A_W   = (WEIGHT_WIDTH > DIFF_W) ? WEIGHT_WIDTH : DIFF_W;
  localparam int MUL_B_W   = GAIN_W;
  localparam int DIGIT_W   = 4;
  localparam int NUM_DIG   = MUL_B_W / DIGIT_W;
  localparam int DIG_CNT_W = $clog2(NUM_DIG + 1);
  localparam int ACC_W     = MUL_A_W + DIGIT_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int RND_W     = PROD_W - FRAC_W;

  localparam int RUN_W = $clog2(MAX_REJECTS + 1);
  localparam int JMP_W = (WEIGHT_WIDTH + 1 > GLITCH_W) ? WEIGHT_WIDTH + 1 : GLITCH_W + 1;
  localparam int CMP_W = (WEIGHT_WIDTH > 21) ? WEIGHT_WIDTH + 1 : 23;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE   = 2'd0,
    ERR_RANGE  = 2'd1,
    ERR_NEG    = 2'd2,
    ERR_NOREAD = 2'd3
  } err_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAW_OFFSET   = 3'd0,
    REG_COUNT_GAIN   = 3'd1,
    REG_TRIM_FACTOR  = 3'd2,
    REG_TARE_WEIGHT  = 3'd3,
    REG_GLITCH_LIMIT = 3'd4,
    REG_CAPACITY     = 3'd5,
    REG_MISSED_LIMIT = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN,
    ST_GROSS,
    ST_JUMP,
    ST_JUDGE,
    ST_TRIM,
    ST_NET,
    ST_CHECK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                      start;
    logic signed [MUL_A_W-1:0] mcand;
    logic [MUL_B_W-1:0]        mplier;
  } mul_req_t;

endpackage

`default_nettype wire

FILE: rtl/core/load_cell_deglitch_weigher_core.sv
// a tick without a sample goes from idle straight to ST_DONE; a tick with a sample
//   passes ST_GAIN, ST_GROSS, ST_JUMP, ST_JUDGE, ST_TRIM, ST_NET and ST_CHECK first
// a new tick is taken only in ST_IDLE, and ST_DONE waits for a free output register;
//   a sample takes two passes through the shared 4-bit serial multiplier, 6 digits each
// reset (rst, synchronous, active high) restores the configuration registers to their
//   defaults, clears the weight state and error and empties the output register
`timescale 1ns / 1ps
`default_nettype none

module load_cell_deglitch_weigher_core
  import lcdw_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  // input ticks
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [RAW_W-1:0]       s_axis_tdata,   // raw_sample
  input  wire logic [0:0]             s_axis_tuser,   // sample_valid
  // results
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // net_weight, gross_weight, error_code
  output logic [0:0]                  m_axis_tuser    // sample_rejected
);

  localparam logic signed [RND_W:0] W_MAX =
    (RND_W + 1)'((64'sd1 <<< (WEIGHT_WIDTH - 1)) - 64'sd1);
  localparam logic signed [RND_W:0] W_MIN =
    (RND_W + 1)'(-(64'sd1 <<< (WEIGHT_WIDTH - 1)));

  function automatic logic signed [WEIGHT_WIDTH-1:0] sat_w(input logic signed [RND_W:0] v);
    priority if (v > W_MAX) begin
      return W_MAX[WEIGHT_WIDTH-1:0];
    end else if (v < W_MIN) begin
      return W_MIN[WEIGHT_WIDTH-1:0];
    end else begin
      return v[WEIGHT_WIDTH-1:0];
    end
  endfunction

  // configuration registers
  logic signed [RAW_W-1:0]  raw_offset;
  logic [GAIN_W-1:0]        count_gain;
  logic [TRIM_W-1:0]        trim_factor;
  logic signed [TARE_W-1:0] tare_weight;
  logic [GLITCH_W-1:0]      glitch_limit;
  logic [CAP_W-1:0]         capacity;
  logic [MISSED_W-1:0]      missed_limit;

  // weigher state
  state_t                          state;
  state_t                          state_next;
  logic signed [WEIGHT_WIDTH-1:0]  accepted_gross;
  logic                            first_pending;
  logic [RUN_W-1:0]                reject_run;
  logic [MISSED_W-1:0]             missed_ticks;
  err_t                            sticky_error;
  logic signed [WEIGHT_WIDTH-1:0]  last_net;
  logic                            rejected;

  // working registers
  logic signed [RND_W-1:0]         rnd;
  logic signed [WEIGHT_WIDTH-1:0]  gross_cand;
  logic [JMP_W-1:0]                jump_abs;

  // output register
  logic [OUT_FIELD_W-1:0]          out_net;
  logic [OUT_FIELD_W-1:0]          out_gross;
  err_t                            out_err;
  logic                            out_rej;

  // datapath nets
  mul_req_t                        mul_req;
  logic                            mul_done;
  logic signed [PROD_W-1:0]        mul_product;
  logic signed [PROD_W-1:0]        rnd_sum;
  logic signed [DIFF_W-1:0]        diff;
  logic signed [JMP_W-1:0]         jump;
  logic                            accept_new;
  logic signed [WEIGHT_WIDTH-1:0]  judge_gross;
  logic [MISSED_W-1:0]             missed_inc;
  logic signed [CMP_W-1:0]         net_ext;
  logic signed [CMP_W-1:0]         cap_lim;
  logic signed [CMP_W-1:0]         neg_lim;
  logic                            in_xfer;
  logic                            out_free;
  logic                            rnd_load;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    diff        = DIFF_W'($signed(s_axis_tdata)) - DIFF_W'(raw_offset);
    rnd_sum     = mul_product
                  + signed'({{(PROD_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}});
    jump        = JMP_W'(gross_cand) - JMP_W'(accepted_gross);
    accept_new  = first_pending || (jump_abs <= JMP_W'(glitch_limit))
                  || (reject_run >= RUN_W'(MAX_REJECTS));
    judge_gross = accept_new ? gross_cand : accepted_gross;
    missed_inc  = (missed_ticks == '1) ? missed_ticks : missed_ticks + 1'b1;
    net_ext     = CMP_W'(last_net);
    cap_lim     = signed'(CMP_W'(capacity) + CMP_W'(MARGIN));
    neg_lim     = -signed'(CMP_W'(MARGIN));
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_offset   <= '0;
      count_gain   <= GAIN_W'(65536);
      trim_factor  <= TRIM_W'(65536);
      tare_weight  <= '0;
      glitch_limit <= GLITCH_W'(1600);
      capacity     <= CAP_W'(24000);
      missed_limit <= MISSED_W'(50);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_RAW_OFFSET:   raw_offset   <= cfg_data[RAW_W-1:0];
        REG_COUNT_GAIN:   count_gain   <= cfg_data[GAIN_W-1:0];
        REG_TRIM_FACTOR:  trim_factor  <= cfg_data[TRIM_W-1:0];
        REG_TARE_WEIGHT:  tare_weight  <= cfg_data[TARE_W-1:0];
        REG_GLITCH_LIMIT: glitch_limit <= cfg_data[GLITCH_W-1:0];
        REG_CAPACITY:     capacity     <= cfg_data[CAP_W-1:0];
        REG_MISSED_LIMIT: missed_limit <= cfg_data[MISSED_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_axis_tvalid) state_next = s_axis_tuser[0] ? ST_GAIN : ST_DONE;
      ST_GAIN:  if (mul_done) state_next = ST_GROSS;
      ST_GROSS: state_next = ST_JUMP;
      ST_JUMP:  state_next = ST_JUDGE;
      ST_JUDGE: state_next = ST_TRIM;
      ST_TRIM:  if (mul_done) state_next = ST_NET;
      ST_NET:   state_next = ST_CHECK;
      ST_CHECK: state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready  = 1'b0;
    rnd_load       = 1'b0;
    mul_req.start  = 1'b0;
    mul_req.mcand  = MUL_A_W'(diff);
    mul_req.mplier = count_gain;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        mul_req.start = s_axis_tvalid && s_axis_tuser[0];
      end
      ST_GAIN, ST_TRIM: rnd_load = mul_done;
      ST_JUDGE: begin
        mul_req.start  = 1'b1;
        mul_req.mcand  = MUL_A_W'(judge_gross);
        mul_req.mplier = MUL_B_W'(trim_factor);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  lcdw_ser_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .done    (mul_done),
    .product (mul_product)
  );

  // weigher state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_gross <= '0;
      first_pending  <= 1'b1;
      reject_run     <= '0;
      missed_ticks   <= '0;
      sticky_error   <= ERR_NONE;
      last_net       <= '0;
      rejected       <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            rejected     <= 1'b0;
            missed_ticks <= s_axis_tuser[0] ? '0 : missed_inc;
            if (missed_inc > missed_limit) sticky_error <= ERR_NOREAD;
          end
        end
        ST_JUDGE: begin
          if (accept_new) begin
            accepted_gross <= gross_cand;
            reject_run     <= '0;
            first_pending  <= 1'b0;
          end else begin
            reject_run <= reject_run + 1'b1;
            rejected   <= 1'b1;
          end
        end
        ST_NET: last_net <= sat_w((RND_W + 1)'(rnd) - (RND_W + 1)'(tare_weight));
        ST_CHECK: begin
          priority if (net_ext > cap_lim) begin
            sticky_error <= ERR_RANGE;
          end else if (net_ext < neg_lim) begin
            sticky_error <= ERR_NEG;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (rnd_load) rnd <= rnd_sum[PROD_W-1:FRAC_W];
    if (state == ST_GROSS) gross_cand <= sat_w((RND_W + 1)'(rnd));
    if (state == ST_JUMP) jump_abs <= (jump < 0) ? JMP_W'(-jump) : JMP_W'(jump);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_net   <= OUT_FIELD_W'(last_net);
      out_gross <= OUT_FIELD_W'(accepted_gross);
      out_err   <= sticky_error;
      out_rej   <= rejected;
    end
  end

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_err, out_gross, out_net};
  assign m_axis_tuser = out_rej;

`ifndef ASSERT_OFF
  a_empty_tick_short: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !s_axis_tuser[0]) |=> (state == ST_DONE))
    else $error("tick without a sample did not go straight to the result");

  a_mul_done_waited: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_GAIN || state == ST_TRIM))
    else $error("multiplier finished outside a waiting state");

  a_reject_run_bound: assert property (@(posedge clk) disable iff (rst)
    reject_run <= RUN_W'(MAX_REJECTS))
    else $error("rejection run beyond its limit");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (sticky_error != ERR_NONE) |=> (sticky_error != ERR_NONE))
    else $error("sticky error cleared without reset");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/lcdw_ser_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module lcdw_ser_mul
  import lcdw_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire mul_req_t                 req,
  output logic                          done,
  output logic signed [PROD_W-1:0]      product
);

  logic                      busy;
  logic [DIG_CNT_W-1:0]      cnt;
  logic signed [MUL_A_W-1:0] a_reg;
  logic [MUL_B_W-1:0]        b_sh;
  logic signed [ACC_W-1:0]   acc;
  logic [MUL_B_W-1:0]        lo_sh;

  logic signed [DIGIT_W:0]   d_s;
  logic signed [ACC_W-1:0]   pp;
  logic signed [ACC_W-1:0]   sum;
  logic signed [ACC_W-1:0]   acc_next;
  logic [MUL_B_W-1:0]        lo_next;

  // one multiplier digit per cycle, least significant first
  always_comb begin
    d_s      = signed'({1'b0, b_sh[DIGIT_W-1:0]});
    pp       = ACC_W'(a_reg) * ACC_W'(d_s);
    sum      = acc + pp;
    acc_next = sum >>> DIGIT_W;
    lo_next  = {sum[DIGIT_W-1:0], lo_sh[MUL_B_W-1:DIGIT_W]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIG_CNT_W'(NUM_DIG);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIG_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_reg <= req.mcand;
      b_sh  <= req.mplier;
      acc   <= '0;
      lo_sh <= '0;
    end else if (busy) begin
      acc   <= acc_next;
      lo_sh <= lo_next;
      b_sh  <= b_sh >> DIGIT_W;
    end
  end

  assign product = {acc[MUL_A_W-1:0], lo_sh};

endmodule

`default_nettype wire
